>>> rtl/core/hsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

  // Default code geometry: 57 data bits and 6 check bits give a 63-position
  // Hamming code plus one overall parity bit, filling a 64-bit word.
  localparam int unsigned DataBitsDef  = 57;
  localparam int unsigned CheckBitsDef = 6;

  // Fixed field widths of the ports.
  localparam int unsigned WordW   = 64;
  localparam int unsigned DataW   = 57;
  localparam int unsigned SyndW   = 6;
  localparam int unsigned StatusW = 3;

  // Request kind.
  localparam logic KindEncode = 1'b0;
  localparam logic KindDecode = 1'b1;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_CLEAN  = 3'd0,
    ST_DOUBLE = 3'd1,
    ST_PARITY = 3'd2,
    ST_SINGLE = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  function automatic logic is_pow2(input int unsigned p);
    return (p & (p - 1)) == 0;
  endfunction

  // Bits 0 to code_len inclusive: the positions plus the overall parity bit.
  function automatic logic [WordW-1:0] word_mask(input int unsigned code_len);
    logic [WordW-1:0] m;
    m = '0;
    for (int unsigned b = 0; b < WordW; b++) begin
      if (b <= code_len) begin
        m[b] = 1'b1;
      end
    end
    return m;
  endfunction

  // Positions covered by syndrome bit bit_idx.
  function automatic logic [WordW-1:0] syn_mask(input int unsigned bit_idx,
                                                input int unsigned code_len);
    logic [WordW-1:0] m;
    m = '0;
    for (int unsigned p = 1; p < WordW; p++) begin
      if (p <= code_len && ((p >> bit_idx) & 1) == 1) begin
        m[p-1] = 1'b1;
      end
    end
    return m;
  endfunction

  // Places the data bits, first bit first, into the positions that are not
  // powers of two; check bit positions are left at zero.
  function automatic logic [WordW-1:0] scatter(input logic [DataW-1:0] data,
                                               input int unsigned code_len,
                                               input int unsigned data_bits);
    logic [WordW-1:0] w;
    int unsigned      d;
    w = '0;
    d = 0;
    for (int unsigned p = 1; p < WordW; p++) begin
      if (p <= code_len && !is_pow2(p)) begin
        if (d < data_bits && d < DataW) begin
          w[p-1] = data[d];
        end
        d++;
      end
    end
    return w;
  endfunction

  // Reads the data bits back out of a code word.
  function automatic logic [DataW-1:0] gather(input logic [WordW-1:0] w,
                                              input int unsigned code_len,
                                              input int unsigned data_bits);
    logic [DataW-1:0] data;
    int unsigned      d;
    data = '0;
    d    = 0;
    for (int unsigned p = 1; p < WordW; p++) begin
      if (p <= code_len && !is_pow2(p)) begin
        if (d < data_bits && d < DataW) begin
          data[d] = w[p-1];
        end
        d++;
      end
    end
    return data;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hsc_syndrome.sv
`timescale 1ns / 1ps
`default_nettype none

// Syndrome and overall parity of a word whose bits above the code are zero.
module hsc_syndrome
  import hsc_pkg::*;
#(
  parameter int unsigned CODE_LEN = DataBitsDef + CheckBitsDef
) (
  input  wire logic [WordW-1:0] word_i,
  output logic      [SyndW-1:0] syndrome_o,
  output logic                  parity_o
);

  for (genvar i = 0; i < SyndW; i++) begin : g_syn
    localparam logic [WordW-1:0] Mask = syn_mask(i, CODE_LEN);
    assign syndrome_o[i] = ^(word_i & Mask);
  end

  assign parity_o = ^word_i;

endmodule

`default_nettype wire

>>> rtl/core/hamming_secded_codec_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Extended Hamming SECDED codec. Each transfer on the input channel is either
// an encode request (kind_i low: data_word_i is spread over the non-power-of-
// two positions, the check bits and the overall parity bit are added) or a
// decode request (kind_i high: code_word_i is checked and, where possible,
// corrected). Every request gives exactly one result transfer with the code
// word, the data bits read from it, a status (clean, double error left
// unchanged, parity bit fixed, single bit fixed, syndrome beyond the code)
// and the syndrome as the one-based error position. The block takes one
// request per clock and delivers one result per clock when the output side
// does not stall. There are three register stages (input capture, syndrome
// and parity trees, correction and output register). The request is captured
// in the input register at its accepting edge, then moves on through the
// syndrome register into the output register, from which the result is
// presented and taken. Bits of code_word_i above the overall parity bit are
// ignored and read back as zero.
module hamming_secded_codec_core
  import hsc_pkg::*;
#(
  parameter int unsigned DATA_BITS  = DataBitsDef,
  parameter int unsigned CHECK_BITS = CheckBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Request channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [DataW-1:0]   data_word_i,
  input  wire logic [WordW-1:0]   code_word_i,
  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [WordW-1:0]        code_out_o,
  output logic [DataW-1:0]        data_out_o,
  output logic [StatusW-1:0]      status_o,
  output logic [SyndW-1:0]        error_position_o
);

  // Number of code positions; the overall parity bit sits just above them.
  localparam int unsigned        CODE_LEN  = DATA_BITS + CHECK_BITS;
  localparam logic [SyndW-1:0]   CodeLenS  = SyndW'(CODE_LEN);
  localparam logic [WordW-1:0]   WordMask  = word_mask(CODE_LEN);

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word;
  } stage1_t;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word;
    logic [SyndW-1:0] syndrome;
    logic             parity;
  } stage2_t;

  // Each stage may load when it is empty or when the stage after it moves
  // on, so a bubble anywhere in the pipeline is squeezed out and a stall at
  // the output holds every occupied stage without loss.
  logic v1_q, v1_d;
  logic v2_q, v2_d;
  logic v3_q, v3_d;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o = !adv1;

  assign v1_d = adv1 ? in_valid_i : v1_q;
  assign v2_d = adv2 ? v1_q       : v2_q;
  assign v3_d = adv3 ? v2_q       : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Stage one: an encode request is spread into its code positions and a
  // decode request has the bits above the code cleared, so both kinds
  // leave this stage as one word for the shared syndrome trees.
  stage1_t s1_q, s1_d;

  always_comb begin
    s1_d.kind = kind_i;
    if (kind_i == KindEncode) begin
      s1_d.word = scatter(data_word_i, CODE_LEN, DATA_BITS);
    end else begin
      s1_d.word = code_word_i & WordMask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv1) begin
      s1_q <= s1_d;
    end
  end

  // Stage two: syndrome and overall parity.
  stage2_t          s2_q, s2_d;
  logic [SyndW-1:0] syn1;
  logic             par1;

  hsc_syndrome #(
    .CODE_LEN (CODE_LEN)
  ) u_syndrome (
    .word_i     (s1_q.word),
    .syndrome_o (syn1),
    .parity_o   (par1)
  );

  assign s2_d = '{kind: s1_q.kind, word: s1_q.word, syndrome: syn1, parity: par1};

  always_ff @(posedge clk_i) begin
    if (v1_q && adv2) begin
      s2_q <= s2_d;
    end
  end

  // Stage three: for an encode the syndrome of the data-only word is exactly
  // the set of check bits to insert, and the overall parity follows from the
  // data parity and those check bits. For a decode the syndrome and parity
  // classify the word, and a correctable error is flipped back.
  logic [WordW-1:0] ins;
  logic [WordW-1:0] word_fix;
  logic [DataW-1:0] data_d;
  status_e          status_d;
  logic [SyndW-1:0] epos_d;

  always_comb begin
    ins      = '0;
    word_fix = s2_q.word;
    status_d = ST_CLEAN;
    epos_d   = '0;
    for (int i = 0; i < SyndW; i++) begin
      if ((1 << i) <= CODE_LEN) begin
        ins[(1 << i) - 1] = s2_q.syndrome[i];
      end
    end
    if (s2_q.kind == KindEncode) begin
      word_fix           = s2_q.word | ins;
      word_fix[CODE_LEN] = s2_q.parity ^ (^ins);
    end else begin
      epos_d = s2_q.syndrome;
      if (s2_q.syndrome == '0 && !s2_q.parity) begin
        status_d = ST_CLEAN;
      end else if (!s2_q.parity) begin
        status_d = ST_DOUBLE;
      end else if (s2_q.syndrome == '0) begin
        status_d           = ST_PARITY;
        word_fix[CODE_LEN] = ~s2_q.word[CODE_LEN];
      end else if (s2_q.syndrome > CodeLenS) begin
        status_d = ST_RANGE;
      end else begin
        status_d = ST_SINGLE;
        word_fix = s2_q.word ^ (WordW'(1) << (s2_q.syndrome - SyndW'(1)));
      end
    end
    data_d = gather(word_fix, CODE_LEN, DATA_BITS);
  end

  logic [WordW-1:0] code_q;
  logic [DataW-1:0] data_q;
  status_e          status_q;
  logic [SyndW-1:0] epos_q;

  always_ff @(posedge clk_i) begin
    if (v2_q && adv3) begin
      code_q   <= word_fix;
      data_q   <= data_d;
      status_q <= status_d;
      epos_q   <= epos_d;
    end
  end

  assign out_valid_o      = v3_q;
  assign code_out_o       = code_q;
  assign data_out_o       = data_q;
  assign status_o         = status_q;
  assign error_position_o = epos_q;

endmodule

`default_nettype wire

>>> rtl/core/hsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hsc_checker
  import hsc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [WordW-1:0]   code_out_o,
  input wire logic [StatusW-1:0] status_o,
  input wire logic [SyndW-1:0]   error_position_o
);

  // A result that is held back stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_out_o)
      && $stable(status_o) && $stable(error_position_o))
    else $error("held result changed");

  // With no result waiting, the pipeline always has room for a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled while the output side is empty");

  // A clean word or a fixed parity bit has a zero syndrome.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CLEAN || status_o == ST_PARITY)
      |-> error_position_o == '0)
    else $error("nonzero position without a located error");

  // A corrected single error always names a position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SINGLE |-> error_position_o != '0)
    else $error("single error fixed at position zero");

endmodule

bind hamming_secded_codec_core hsc_checker u_hsc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .code_out_o       (code_out_o),
  .status_o         (status_o),
  .error_position_o (error_position_o)
);

`default_nettype wire
